// ----- design/rsp_pkg.sv -----
// shared types and constants for the road segment projector
`default_nettype none

package rsp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_DEPTH    = 3'd0,
    REG_ROAD_WIDTH   = 3'd1,
    REG_SCREEN_WIDTH = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_TRACK_LENGTH = 3'd4
  } rsp_reg_e;

  // register reset values
  localparam logic [15:0] CAM_DEPTH_RST     = 16'd13763;
  localparam logic [15:0] ROAD_WIDTH_RST    = 16'd2000;
  localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd1024;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd768;
  localparam logic [23:0] TRACK_LENGTH_RST  = 24'd320000;

  // item kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_SEG   = 1'b1;

  // datapath sizes fixed by the field widths
  localparam int SCREEN_DIM_W = 12;
  localparam int REL_W        = 25;
  localparam int MAC_CHUNK_W  = 16;
  localparam int CAP_MAG      = 65536;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_y;
    logic        [23:0] cam_z;
    logic signed [23:0] seg_y;
    logic        [23:0] seg_z;
    logic signed [15:0] seg_curve;
    logic               seg_wrapped;
  } rsp_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic signed [15:0] screen_half_width;
    logic               visible;
    logic        [11:0] clip_y;
  } rsp_out_t;

  // multiply-accumulate control
  typedef struct packed {
    logic       en;
    logic       clr;
    logic [1:0] chunk;
  } rsp_mac_ctl_t;

endpackage

`default_nettype wire

// ----- design/rsp_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module rsp_div #(
  parameter int QW = 26,
  parameter int DW = 25
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [QW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [QW-1:0]      quot_o
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] num_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, num_q[QW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[QW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

// ----- design/rsp_mac.sv -----
// shared multiply-accumulate unit, one 16-bit multiplier slice per cycle while enabled
`default_nettype none

module rsp_mac
  import rsp_pkg::*;
#(
  parameter int MW = 38,
  parameter int AW = 86
) (
  input  wire logic                   clk_i,
  input  wire rsp_mac_ctl_t           ctl_i,
  input  wire logic [MW-1:0]          a_i,
  input  wire logic [MAC_CHUNK_W-1:0] b_i,
  output logic [AW-1:0]               acc_o
);

  logic [MW+MAC_CHUNK_W-1:0] prod;
  logic [AW-1:0]             term;
  logic [AW-1:0]             acc_q;

  assign prod = a_i * b_i;
  // slice k of the multiplier weighs 2^(16k)
  assign term = AW'(prod) << {ctl_i.chunk, 4'b0000};

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= ctl_i.clr ? term : acc_q + term;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- design/road_segment_projector.sv -----
// top level of the pseudo-3d road segment projector
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per item.
//   a frame-start beat loads camera x, y, z, clears curve offset and slope and
//   resets the horizon to screen_height; it leaves the block idle and gives no result.
//   a segment beat gives exactly one result beat on the output channel
//   (out_valid_o / out_stall_i / out_data_o) with screen x, y, half width,
//   visibility and the clip line (horizon before this segment).
//   a segment is accepted, goes through the restoring divider and its done flag,
//   then through the shared 16-bit-slice multiply-accumulate unit, and ends in
//   the finish and output-load steps. depth not positive skips the divider and
//   multiplier and goes to the output load with zero position, half width
//   and visibility.
//   in_stall_o is high while a segment is in work.
//   the output register holds a result while out_stall_i is high; a new item is
//   still taken, and its result waits in the last step until the register frees.
//   configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are registered directly.
//   reset (rst_ni low, asynchronous) restores the register defaults, clears the
//   camera and curve state, sets the horizon to 768 and empties the output.
`default_nettype none

module road_segment_projector
  import rsp_pkg::*;
#(
  parameter int SCALE_FRAC_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire rsp_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output rsp_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int F   = SCALE_FRAC_BITS;
  localparam int QW  = F + 2;                      // scale quotient width
  localparam int MW  = QW + SCREEN_DIM_W;          // scale times screen dimension
  localparam int AW  = MW + 3 * MAC_CHUNK_W;       // accumulator width
  localparam int SHX = F + 9;
  localparam int SHY = F + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SW,
    ST_SH,
    ST_X,
    ST_Y,
    ST_HW,
    ST_FIN,
    ST_EMIT
  } state_e;

  // configuration registers
  logic [15:0] cam_depth_q;
  logic [15:0] road_w_q;
  logic [11:0] scr_w_q;
  logic [11:0] scr_h_q;
  logic [23:0] track_len_q;

  // camera and curve state
  logic signed [23:0] cam_x_q;
  logic signed [23:0] cam_y_q;
  logic        [23:0] cam_z_q;
  logic signed [31:0] curve_off_q;
  logic signed [23:0] curve_slope_q;
  logic signed [15:0] horizon_q;

  // sequencer and output
  state_e   state_q;
  logic [1:0] chunk_q;
  logic     out_valid_q;
  rsp_out_t out_q;

  // per-segment working registers
  logic [32:0]        dx_mag_q;
  logic               dx_neg_q;
  logic [24:0]        dy_mag_q;
  logic               dy_neg_q;
  logic [11:0]        clip_q;
  logic [MW-1:0]      a_q;      // scale * screen width
  logic [MW-1:0]      b_q;      // scale * screen height
  logic signed [15:0] sx_q;
  logic signed [15:0] sy_q;
  logic signed [15:0] hw_q;
  logic               vis_q;

  // accept and per-item arithmetic
  logic               in_acc;
  logic               seg_acc;
  logic signed [25:0] rel;
  logic               rel_pos;
  logic [32:0]        dx;
  logic [24:0]        dy;
  logic [32:0]        off_sum;
  logic [24:0]        slope_sum;
  logic [31:0]        off_sat;
  logic [23:0]        slope_sat;
  logic [11:0]        clip_now;

  // divider
  logic          div_start;
  logic [QW-1:0] div_num;
  logic          div_done;
  logic [QW-1:0] quot;

  // multiply-accumulate
  rsp_mac_ctl_t           mac_ctl;
  logic [MW-1:0]          mac_a;
  logic [MAC_CHUNK_W-1:0] mac_b;
  logic [AW-1:0]          acc;

  // finish logic
  logic [AW-1:0] shx;
  logic [AW-1:0] shy;
  logic [16:0]   mx;
  logic [16:0]   my;
  logic [17:0]   half_w;
  logic [17:0]   half_h;
  logic [17:0]   sx_raw;
  logic [17:0]   sy_raw;
  logic [15:0]   sx_fin;
  logic [15:0]   sy_fin;
  logic [15:0]   hw_fin;
  logic          fin_vis;
  logic          out_free;

  function automatic logic [15:0] sat16(input logic [17:0] v);
    logic [15:0] r;
    if (v[17:15] == 3'b000 || v[17:15] == 3'b111) begin
      r = v[15:0];
    end else begin
      r = v[17] ? 16'h8000 : 16'h7FFF;
    end
    return r;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign seg_acc    = in_acc && (in_data_i.kind == KIND_SEG);
  assign out_free   = !out_valid_q || !out_stall_i;

  // depth relative to the camera, track length added past the wrap
  assign rel = $signed({2'b00, in_data_i.seg_z}) - $signed({2'b00, cam_z_q})
             + (in_data_i.seg_wrapped ? $signed({2'b00, track_len_q}) : 26'sd0);
  assign rel_pos = !rel[25] && (rel != 26'sd0);

  // lateral offset in signed q25.8 (33 bits) and height difference
  assign dx = {curve_off_q[31], curve_off_q} - {cam_x_q[23], cam_x_q, 8'h00};
  assign dy = {in_data_i.seg_y[23], in_data_i.seg_y} - {cam_y_q[23], cam_y_q};

  // curve accumulators, both saturating
  assign off_sum   = {curve_off_q[31], curve_off_q} + {{9{curve_slope_q[23]}}, curve_slope_q};
  assign slope_sum = {curve_slope_q[23], curve_slope_q}
                   + {{9{in_data_i.seg_curve[15]}}, in_data_i.seg_curve};

  always_comb begin
    case (off_sum[32:31])
      2'b01:   off_sat = 32'h7FFF_FFFF;
      2'b10:   off_sat = 32'h8000_0000;
      default: off_sat = off_sum[31:0];
    endcase
    case (slope_sum[24:23])
      2'b01:   slope_sat = 24'h7F_FFFF;
      2'b10:   slope_sat = 24'h80_0000;
      default: slope_sat = slope_sum[23:0];
    endcase
  end

  // clip line: horizon clamped to the 12-bit screen range
  assign clip_now = horizon_q[15] ? 12'd0
                  : ((horizon_q[14:12] != 3'd0) ? 12'hFFF : horizon_q[11:0]);

  // scale numerator: cam_depth moved from 14 to F fraction bits
  assign div_num   = QW'(cam_depth_q) << (F - 14);
  assign div_start = seg_acc && rel_pos;

  rsp_div #(
    .QW (QW),
    .DW (REL_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (rel[REL_W-1:0]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // operand selection for the shared multiply-accumulate
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_q)
      ST_SW: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_a       = MW'(quot);
        mac_b       = {4'b0000, scr_w_q};
      end
      ST_SH: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_a       = MW'(quot);
        mac_b       = {4'b0000, scr_h_q};
      end
      ST_X: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clr   = (chunk_q == 2'd0);
        mac_ctl.chunk = chunk_q;
        mac_a         = a_q;
        case (chunk_q)
          2'd0:    mac_b = dx_mag_q[15:0];
          2'd1:    mac_b = dx_mag_q[31:16];
          default: mac_b = {15'd0, dx_mag_q[32]};
        endcase
      end
      ST_Y: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clr   = (chunk_q == 2'd0);
        mac_ctl.chunk = chunk_q;
        mac_a         = b_q;
        mac_b         = (chunk_q == 2'd0) ? dy_mag_q[15:0] : {7'd0, dy_mag_q[24:16]};
      end
      ST_HW: begin
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = 1'b1;
        mac_a       = a_q;
        mac_b       = road_w_q;
      end
      default: ;
    endcase
  end

  rsp_mac #(
    .MW (MW),
    .AW (AW)
  ) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  // finish: scale down, cap at 65536, apply sign around the screen centre
  assign shx    = acc >> SHX;
  assign shy    = acc >> SHY;
  assign mx     = (shx > AW'(CAP_MAG)) ? 17'h1_0000 : shx[16:0];
  assign my     = (shy > AW'(CAP_MAG)) ? 17'h1_0000 : shy[16:0];
  assign half_w = {7'd0, scr_w_q[11:1]};
  assign half_h = {7'd0, scr_h_q[11:1]};
  assign sx_raw = dx_neg_q ? (half_w - {1'b0, mx}) : (half_w + {1'b0, mx});
  assign sy_raw = dy_neg_q ? (half_h + {1'b0, my}) : (half_h - {1'b0, my});
  assign sx_fin = sat16(sx_raw);
  assign sy_fin = sat16(sy_raw);
  assign hw_fin = (my[16:15] != 2'b00) ? 16'h7FFF : {1'b0, my[14:0]};
  assign fin_vis = (sy_q < horizon_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_depth_q <= CAM_DEPTH_RST;
      road_w_q    <= ROAD_WIDTH_RST;
      scr_w_q     <= SCREEN_WIDTH_RST;
      scr_h_q     <= SCREEN_HEIGHT_RST;
      track_len_q <= TRACK_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (rsp_reg_e'(cfg_idx_i))
        REG_CAM_DEPTH:     cam_depth_q <= cfg_wdata_i[15:0];
        REG_ROAD_WIDTH:    road_w_q    <= cfg_wdata_i[15:0];
        REG_SCREEN_WIDTH:  scr_w_q     <= cfg_wdata_i[11:0];
        REG_SCREEN_HEIGHT: scr_h_q     <= cfg_wdata_i[11:0];
        REG_TRACK_LENGTH:  track_len_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // camera, curve and horizon state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q       <= '0;
      cam_y_q       <= '0;
      cam_z_q       <= '0;
      curve_off_q   <= '0;
      curve_slope_q <= '0;
      horizon_q     <= {4'd0, SCREEN_HEIGHT_RST};
    end else begin
      if (in_acc && (in_data_i.kind == KIND_FRAME)) begin
        cam_x_q       <= in_data_i.cam_x;
        cam_y_q       <= in_data_i.cam_y;
        cam_z_q       <= in_data_i.cam_z;
        curve_off_q   <= '0;
        curve_slope_q <= '0;
        horizon_q     <= {4'd0, scr_h_q};
      end else if (seg_acc) begin
        // offset takes the old slope, slope adds the segment curve
        curve_off_q   <= off_sat;
        curve_slope_q <= slope_sat;
      end else if (state_q == ST_FIN && fin_vis) begin
        horizon_q <= sy_q;
      end
    end
  end

  // sequencer with registered output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // the emit step reloads the register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (seg_acc) begin
            state_q <= rel_pos ? ST_DIV : ST_EMIT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_SW;
          end
        end
        ST_SW: begin
          state_q <= ST_SH;
        end
        ST_SH: begin
          state_q <= ST_X;
          chunk_q <= 2'd0;
        end
        ST_X: begin
          if (chunk_q == 2'd2) begin
            state_q <= ST_Y;
            chunk_q <= 2'd0;
          end else begin
            chunk_q <= chunk_q + 2'd1;
          end
        end
        ST_Y: begin
          if (chunk_q == 2'd1) begin
            state_q <= ST_HW;
            chunk_q <= 2'd0;
          end else begin
            chunk_q <= chunk_q + 2'd1;
          end
        end
        ST_HW: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q             <= 1'b1;
            out_q.screen_x          <= sx_q;
            out_q.screen_y          <= sy_q;
            out_q.screen_half_width <= hw_q;
            out_q.visible           <= vis_q;
            out_q.clip_y            <= clip_q;
            state_q                 <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // per-segment working registers
  always_ff @(posedge clk_i) begin
    if (seg_acc) begin
      dx_neg_q <= dx[32];
      dx_mag_q <= dx[32] ? (33'd0 - dx) : dx;
      dy_neg_q <= dy[24];
      dy_mag_q <= dy[24] ? (25'd0 - dy) : dy;
      clip_q   <= clip_now;
      sx_q     <= '0;
      sy_q     <= '0;
      hw_q     <= '0;
      vis_q    <= 1'b0;
    end
    if (state_q == ST_SH) begin
      a_q <= acc[MW-1:0];
    end
    if (state_q == ST_X && chunk_q == 2'd0) begin
      b_q <= acc[MW-1:0];
    end
    if (state_q == ST_Y && chunk_q == 2'd0) begin
      sx_q <= sx_fin;
    end
    if (state_q == ST_HW) begin
      sy_q <= sy_fin;
    end
    if (state_q == ST_FIN) begin
      hw_q  <= hw_fin;
      vis_q <= fin_vis;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  // the horizon never rises inside a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> (horizon_q <= $past(horizon_q)))
    else $error("horizon moved up on a segment");

  // a visible segment leaves its own y as the new horizon
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && fin_vis) |=> (horizon_q == sy_q && vis_q))
    else $error("visible segment did not lower the horizon");

  // a finished segment with a free output register is delivered next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result beat not loaded");

endmodule

`default_nettype wire
